@@ sv/wiegand_frame_transmitter_unit_assert.svh @@
// assertion macros used by the wiegand transmitter top
`ifndef WIEGAND_FRAME_TRANSMITTER_UNIT_ASSERT_SVH
`define WIEGAND_FRAME_TRANSMITTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wft assertion failed");

// next-cycle implication, checked out of reset
`define WFT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wft assertion failed");

`endif

@@ sv/wft_pkg.sv @@
// types, constants and frame helpers for the wiegand transmitter
package wft_pkg;

  localparam int PAY_W   = 40;
  localparam int FRAME_W = 42;
  localparam int CNT_W   = 6;
  localparam int TICK_W  = 16;

  localparam logic [TICK_W-1:0] PULSE_RESET = 16'd100;
  localparam logic [TICK_W-1:0] GAP_RESET   = 16'd2000;

  localparam logic [CNT_W-1:0] BITS_26 = 6'd26;
  localparam logic [CNT_W-1:0] BITS_42 = 6'd42;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic {
    FMT_26 = 1'b0,
    FMT_42 = 1'b1
  } fmt_t;

  typedef enum logic {
    CFG_PULSE_TICKS = 1'b0,
    CFG_GAP_TICKS   = 1'b1
  } cfg_idx_t;

  // one frame ready to load into the sequencer
  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [CNT_W-1:0]   count;
  } frame_t;

  // one result item
  typedef struct packed {
    logic data0_line;
    logic data1_line;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } res_t;

endpackage

@@ sv/wiegand_frame_transmitter_unit.sv @@
// wiegand 26/42-bit transmitter top: config registers, handshake, result register
// latency: a result item is valid in the cycle after its input item is accepted
// throughput: one item per cycle; in_ready stays high while the result register
// is empty or being taken, so a stalled output blocks only one slot deep
// reset (synchronous, rst_n low): sequencer idle, result register empty,
// pulse_ticks = 100, gap_ticks = 2000
module wiegand_frame_transmitter_unit import wft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [PAY_W-1:0]  in_payload,
  input  logic              in_frame_format,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_data0_line,
  output logic              out_data1_line,
  output logic              out_busy_res,
  output logic              out_frame_done,
  output logic              out_start_rejected,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TICK_W-1:0] cfg_wdata
);

`include "wiegand_frame_transmitter_unit_assert.svh"

  logic [TICK_W-1:0] pulse_ticks_r;
  logic [TICK_W-1:0] gap_ticks_r;
  logic              out_valid_r;
  res_t              res_r;
  res_t              res;
  frame_t            frame;
  logic              in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_RESET;
      gap_ticks_r   <= GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PULSE_TICKS: pulse_ticks_r <= cfg_wdata;
        CFG_GAP_TICKS:   gap_ticks_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame assembly
  wft_frame_build u_build (
    .payload      (in_payload),
    .frame_format (in_frame_format),
    .frame        (frame)
  );

  // bit sequencer
  wft_tx_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_acc),
    .opcode      (in_opcode),
    .frame       (frame),
    .pulse_ticks (pulse_ticks_r),
    .gap_ticks   (gap_ticks_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data0_line     = res_r.data0_line;
  assign out_data1_line     = res_r.data1_line;
  assign out_busy_res       = res_r.busy_res;
  assign out_frame_done     = res_r.frame_done;
  assign out_start_rejected = res_r.start_rejected;

  // checks
  `WFT_ASSERT_NXT(a_acc_gives_result, in_acc, out_valid_r)
  `WFT_ASSERT_IMP(a_one_line_low, out_valid_r, out_data0_line || out_data1_line)
  `WFT_ASSERT_IMP(a_pulse_while_busy, out_valid_r && !(out_data0_line && out_data1_line), out_busy_res)
  `WFT_ASSERT_IMP(a_done_is_idle, out_valid_r && out_frame_done, !out_busy_res)
  `WFT_ASSERT_IMP(a_reject_while_busy, out_valid_r && out_start_rejected, out_busy_res)

endmodule

@@ sv/wft_frame_build.sv @@
// builds the parity-wrapped frame for the 26-bit and 42-bit formats
module wft_frame_build import wft_pkg::*; (
  input  logic [PAY_W-1:0] payload,
  input  logic             frame_format,
  output frame_t           frame
);

  logic [23:0] data26;
  logic        even26;
  logic        odd26;
  logic        even42;
  logic        odd42;

  // parity over each half of the data bits
  assign data26 = payload[23:0];
  assign even26 = ^data26[23:12];
  assign odd26  = ~(^data26[11:0]);
  assign even42 = ^payload[39:20];
  assign odd42  = ~(^payload[19:0]);

  // right-aligned frame: even parity, data msb first, odd parity
  always_comb begin
    if (frame_format == FMT_42) begin
      frame.bits  = {even42, payload, odd42};
      frame.count = BITS_42;
    end else begin
      frame.bits  = {16'd0, even26, data26, odd26};
      frame.count = BITS_26;
    end
  end

endmodule

@@ sv/wft_tx_seq.sv @@
// bit sequencer: frame shift register, bit counter and pulse/gap timer
module wft_tx_seq import wft_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              opcode,
  input  frame_t            frame,
  input  logic [TICK_W-1:0] pulse_ticks,
  input  logic [TICK_W-1:0] gap_ticks,
  output res_t              res
);

  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]   bits_r, bits_nxt;
  logic [TICK_W-1:0]  phase_r, phase_nxt;
  logic               in_pulse_r, in_pulse_nxt;
  logic               sending_r, sending_nxt;

  logic [TICK_W-1:0]  phase_inc;
  logic [CNT_W-1:0]   bits_dec;
  logic [CNT_W-1:0]   bit_pos;
  logic               cur_bit;
  logic               line_active;
  logic               done;
  logic               rejected;

  assign phase_inc = phase_r + 1'b1;
  assign bits_dec  = (bits_r != '0) ? bits_r - 1'b1 : bits_r;

  // next state for one item
  always_comb begin
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    phase_nxt    = phase_r;
    in_pulse_nxt = in_pulse_r;
    sending_nxt  = sending_r;
    done         = 1'b0;
    rejected     = 1'b0;
    if (opcode == OP_START) begin
      if (sending_r) begin
        rejected = 1'b1;
      end else begin
        shift_nxt    = frame.bits;
        bits_nxt     = frame.count;
        phase_nxt    = '0;
        in_pulse_nxt = 1'b1;
        sending_nxt  = 1'b1;
      end
    end else if (sending_r) begin
      phase_nxt = phase_inc;
      if (in_pulse_r) begin
        if (phase_inc >= pulse_ticks) begin
          in_pulse_nxt = 1'b0;
          phase_nxt    = '0;
        end
      end else if (phase_inc >= gap_ticks) begin
        phase_nxt = '0;
        bits_nxt  = bits_dec;
        if (bits_dec == '0) begin
          sending_nxt = 1'b0;
          shift_nxt   = '0;
          done        = 1'b1;
        end else begin
          in_pulse_nxt = 1'b1;
        end
      end
    end
  end

  // line levels after the item
  assign bit_pos     = bits_nxt - 1'b1;
  assign cur_bit     = (bit_pos < CNT_W'(FRAME_W)) ? shift_nxt[bit_pos] : 1'b0;
  assign line_active = sending_nxt && in_pulse_nxt && (bits_nxt != '0);

  always_comb begin
    res.data0_line     = !(line_active && !cur_bit);
    res.data1_line     = !(line_active && cur_bit);
    res.busy_res       = sending_nxt;
    res.frame_done     = done;
    res.start_rejected = rejected;
  end

  // state registers, advanced once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      bits_r     <= '0;
      phase_r    <= '0;
      in_pulse_r <= 1'b0;
      sending_r  <= 1'b0;
    end else if (step_en) begin
      shift_r    <= shift_nxt;
      bits_r     <= bits_nxt;
      phase_r    <= phase_nxt;
      in_pulse_r <= in_pulse_nxt;
      sending_r  <= sending_nxt;
    end
  end

endmodule

@@ dv/tb_wiegand_frame_transmitter_unit.sv @@
// testbench for the wiegand 26/42-bit frame transmitter: random ticks and starts, scoreboard
module tb_wiegand_frame_transmitter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wft_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  op_t               in_opcode;
  logic [PAY_W-1:0]  in_payload;
  fmt_t              in_frame_format;
  logic              out_valid;
  logic              out_ready;
  logic              out_data0_line;
  logic              out_data1_line;
  logic              out_busy_res;
  logic              out_frame_done;
  logic              out_start_rejected;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [TICK_W-1:0] cfg_wdata;

  // stimulus shaping flags
  bit calm;
  bit hold_request;
  bit hold_served;

  wiegand_frame_transmitter_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_payload        (in_payload),
    .in_frame_format   (in_frame_format),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data0_line    (out_data0_line),
    .out_data1_line    (out_data1_line),
    .out_busy_res      (out_busy_res),
    .out_frame_done    (out_frame_done),
    .out_start_rejected(out_start_rejected),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // predicts the line levels of each item and checks them in order
  class wiegand_scoreboard;
    logic [TICK_W-1:0]  pulse_len;
    logic [TICK_W-1:0]  gap_len;
    logic [FRAME_W-1:0] frame_bits;
    logic [CNT_W-1:0]   bits_left;
    logic [TICK_W-1:0]  tick_count;
    bit                 pulse_on;
    bit                 busy;
    res_t               line_levels_q[$];
    int                 errors;

    function new();
      pulse_len  = PULSE_RESET;
      gap_len    = GAP_RESET;
      frame_bits = '0;
      bits_left  = '0;
      tick_count = '0;
      pulse_on   = 1'b0;
      busy       = 1'b0;
      errors     = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [TICK_W-1:0] val);
      if (idx == CFG_PULSE_TICKS) pulse_len = val;
      else gap_len = val;
    endfunction

    function int pending();
      return line_levels_q.size();
    endfunction

    // advance the transmitter by one accepted item and queue the levels it shows
    function void note_item(op_t op, logic [PAY_W-1:0] payload, fmt_t fmt);
      res_t             want;
      logic [PAY_W-1:0] data;
      logic             even_bit;
      logic             odd_bit;
      want = '0;
      want.data0_line = 1'b1;
      want.data1_line = 1'b1;
      if (op == OP_START) begin
        // start while busy is dropped and flagged, no time passes
        if (busy) begin
          want.start_rejected = 1'b1;
        end else begin
          if (fmt == FMT_42) begin
            data       = payload;
            even_bit   = ^data[39:20];
            odd_bit    = ~(^data[19:0]);
            frame_bits = {even_bit, data, odd_bit};
            bits_left  = BITS_42;
          end else begin
            // bits above the low 24 are ignored in the short format
            data       = {16'd0, payload[23:0]};
            even_bit   = ^data[23:12];
            odd_bit    = ~(^data[11:0]);
            frame_bits = {16'd0, even_bit, data[23:0], odd_bit};
            bits_left  = BITS_26;
          end
          tick_count = '0;
          pulse_on   = 1'b1;
          busy       = 1'b1;
        end
      end else if (busy) begin
        // a zero length acts as one tick since the count is compared after the increment
        tick_count = tick_count + 1'b1;
        if (pulse_on) begin
          if (tick_count >= pulse_len) begin
            pulse_on   = 1'b0;
            tick_count = '0;
          end
        end else if (tick_count >= gap_len) begin
          tick_count = '0;
          if (bits_left != 0) bits_left = bits_left - 1'b1;
          if (bits_left == 0) begin
            busy            = 1'b0;
            frame_bits      = '0;
            want.frame_done = 1'b1;
          end else begin
            pulse_on = 1'b1;
          end
        end
      end
      // current bit pulls its line low during the pulse
      if (busy && pulse_on && bits_left != 0) begin
        if (frame_bits[bits_left - 1'b1]) want.data1_line = 1'b0;
        else want.data0_line = 1'b0;
      end
      want.busy_res = busy;
      line_levels_q.push_back(want);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want) report($sformatf("%s got %b want %b", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (line_levels_q.size() == 0) begin
        report($sformatf("result %b with no item waiting", got));
        return;
      end
      want = line_levels_q.pop_front();
      compare_field("data0_line", got.data0_line, want.data0_line);
      compare_field("data1_line", got.data1_line, want.data1_line);
      compare_field("busy_res", got.busy_res, want.busy_res);
      compare_field("frame_done", got.frame_done, want.frame_done);
      compare_field("start_rejected", got.start_rejected, want.start_rejected);
    endtask
  endclass

  wiegand_scoreboard scoreboard = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor, values sampled as they were at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        scoreboard.check_result({out_data0_line, out_data1_line, out_busy_res,
                                 out_frame_done, out_start_rejected});
      if (in_valid && in_ready)
        scoreboard.note_item(in_opcode, in_payload, in_frame_format);
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("wiegand_frame_transmitter_unit test failed");
    $finish;
  end

  // offer one item, with an optional idle burst first, and wait until taken
  task send_item(op_t op, logic [PAY_W-1:0] payload, fmt_t fmt);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_payload      <= payload;
    in_frame_format <= fmt;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait for every queued result
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scoreboard.pending() != 0);
  endtask

  task write_register(cfg_idx_t idx, logic [TICK_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    scoreboard.set_register(idx, val);
  endtask

  task configure(logic [TICK_W-1:0] pulse, logic [TICK_W-1:0] gap);
    wait_drained();
    repeat (2) @(posedge clk);
    write_register(CFG_PULSE_TICKS, pulse);
    write_register(CFG_GAP_TICKS, gap);
    cfg_we <= 1'b0;
  endtask

  // mostly whole frames: start when idle, ticks while busy, a few stray starts
  task run_random(int count, int hold_at);
    op_t         op;
    fmt_t        fmt;
    logic [63:0] rnd;
    logic [PAY_W-1:0] payload;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      if (scoreboard.busy) op = ($urandom_range(0, 24) == 0) ? OP_START : OP_TICK;
      else op = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_START;
      fmt = fmt_t'($urandom_range(0, 1));
      rnd = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: payload = '0;
        1: payload = {PAY_W{1'b1}};
        default: payload = rnd[PAY_W-1:0];
      endcase
      send_item(op, payload, fmt);
    end
  endtask

  // main sequence
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_TICK;
    in_payload      <= '0;
    in_frame_format <= FMT_26;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_PULSE_TICKS;
    cfg_wdata       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick while idle, short frame with upper bits set, starts while busy
    send_item(OP_TICK, '0, FMT_26);
    send_item(OP_START, {PAY_W{1'b1}}, FMT_26);
    send_item(OP_TICK, '0, FMT_26);
    send_item(OP_TICK, '0, FMT_42);
    send_item(OP_START, '0, FMT_42);
    send_item(OP_START, {PAY_W{1'b1}}, FMT_26);
    send_item(OP_TICK, {PAY_W{1'b1}}, FMT_42);

    // zero lengths behave as one tick
    configure('0, '0);
    send_item(OP_TICK, '0, FMT_26);
    send_item(OP_TICK, '0, FMT_26);
    run_random(150, -1);

    // shortest legal timing, with a long output hold-off
    configure(16'd1, 16'd1);
    run_random(220, 50);

    // longest timing, frames never finish here
    configure(16'hffff, 16'hffff);
    run_random(40, -1);

    configure(16'd2, 16'd3);
    run_random(250, -1);

    configure(TICK_W'($urandom_range(1, 5)), TICK_W'($urandom_range(1, 5)));
    run_random(200, -1);

    // last stretch runs without any idling
    configure(16'd1, 16'd2);
    calm = 1'b1;
    run_random(200, -1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (scoreboard.errors == 0) $display("wiegand_frame_transmitter_unit test passed");
    else $display("wiegand_frame_transmitter_unit test failed");
    $finish;
  end

endmodule
